FILE: src/brr_pkg.sv
package brr_pkg;

    // Fixed field widths
    localparam int unsigned PIX_W    = 32;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_CHAN = PIX_W / CHAN_W;
    localparam int unsigned STORE_AW = 16;
    localparam int unsigned SIZE_W   = 9;
    localparam int unsigned STEP_W   = 24;
    localparam int unsigned DEST_W   = 12;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned CFG_AW   = 2;

    localparam int unsigned SIZE_MAX = (1 << SIZE_W) - 1;

    // Derived datapath widths
    localparam int unsigned POS_W  = DEST_W + STEP_W;      // dest * step
    localparam int unsigned IPOS_W = POS_W - FRAC_W;       // integer part
    localparam int unsigned WGT_W  = 2 * FRAC_W + 1;       // weights reach 2^32
    localparam int unsigned ACC_W  = WGT_W + CHAN_W - 1;   // sum stays below 2^40

    localparam int unsigned MAX_WIDTH_DEF  = 256;
    localparam int unsigned MAX_HEIGHT_DEF = 256;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_AW-1:0]
    {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_X_STEP     = 2'd2,
        CFG_Y_STEP     = 2'd3
    } cfg_idx_t;

endpackage

FILE: src/bilinear_rgba_resampler_unit.sv
// Channel   Handshake                 Payload
// item      item_valid / item_stall   cmd, pixel_index, pixel_rgba, dest_x, dest_y
// result    result_valid / result_stall  out_rgba
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A write beat stores its pixel at the accept edge.
// A sample beat holds the item side through the position multiply, locate,
// weights and addresses, four serial reads of the single-port pixel store
// (one neighbor per cycle), the last accumulate, then the result load.
// The result register frees the item side: a new beat is taken while a result waits.
// Reset clears control and steps and sets the sizes to 1; the store is not cleared.
// cfg_ready is always high.
module bilinear_rgba_resampler_unit
    import brr_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_stall,
    input  logic                cmd,
    input  logic [STORE_AW-1:0] pixel_index,
    input  logic [PIX_W-1:0]    pixel_rgba,
    input  logic [DEST_W-1:0]   dest_x,
    input  logic [DEST_W-1:0]   dest_y,

    output logic                result_valid,
    input  logic                result_stall,
    output logic [PIX_W-1:0]    out_rgba,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_AW-1:0]   cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int unsigned STORE_DEPTH = 1 << STORE_AW;

    // Size clamps; a cap beyond what the 9-bit register can hold never bites
    localparam logic [SIZE_W-1:0] W_CAP =
        (MAX_WIDTH < SIZE_MAX) ? SIZE_W'(MAX_WIDTH) : SIZE_W'(SIZE_MAX);
    localparam logic [SIZE_W-1:0] H_CAP =
        (MAX_HEIGHT < SIZE_MAX) ? SIZE_W'(MAX_HEIGHT) : SIZE_W'(SIZE_MAX);
    localparam logic [FRAC_W:0]   ONE_Q = (FRAC_W + 1)'(1) << FRAC_W;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_LOC,
        S_WGT,
        S_READ,
        S_ACC,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [SIZE_W-1:0] src_width_reg;
    logic [SIZE_W-1:0] src_height_reg;
    logic [STEP_W-1:0] x_step_reg;
    logic [STEP_W-1:0] y_step_reg;

    // Pixel store
    logic [PIX_W-1:0]    store_mem [STORE_DEPTH];
    logic [PIX_W-1:0]    rd_data_reg;
    logic [STORE_AW-1:0] rd_addr;
    logic                rd_en;

    // Sample datapath
    logic [POS_W-1:0]    gx_reg, gy_reg;
    logic [SIZE_W-1:0]   xi_reg, yi_reg;
    logic [FRAC_W-1:0]   fx_reg, fy_reg;
    logic                right_reg, down_reg;
    logic [WGT_W-1:0]    weight_reg [NUM_CHAN];
    logic [STORE_AW-1:0] addr_reg [NUM_CHAN];
    logic [1:0]          rd_cnt_reg;
    logic                acc_en_reg;
    logic [1:0]          acc_sel_reg;
    logic [ACC_W-1:0]    acc_reg [NUM_CHAN];

    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_rgba_reg;

    logic                item_take;
    logic                out_free;

    // Clamped sizes
    logic [SIZE_W-1:0] dim_w, dim_h, dim_w_m1, dim_h_m1;

    // Locate
    logic [IPOS_W-1:0] ix, iy;
    logic              sat_x, sat_y;

    // Weights and addresses
    logic [FRAC_W:0]          nfx, nfy;
    logic [2*FRAC_W+1:0]      wp00, wp10, wp01, wp11;
    logic [2*SIZE_W-1:0]      row_base;
    logic [STORE_AW-1:0]      a00, a10, a01, a11;

    // Accumulate
    logic [WGT_W-1:0]  wsel;
    logic [ACC_W:0]    prod [NUM_CHAN];
    logic [PIX_W-1:0]  out_pack;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign out_rgba     = out_rgba_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    always_comb
    begin
        priority if (src_width_reg == '0)
            dim_w = SIZE_W'(1);
        else if (src_width_reg > W_CAP)
            dim_w = W_CAP;
        else
            dim_w = src_width_reg;

        priority if (src_height_reg == '0)
            dim_h = SIZE_W'(1);
        else if (src_height_reg > H_CAP)
            dim_h = H_CAP;
        else
            dim_h = src_height_reg;
    end

    assign dim_w_m1 = dim_w - SIZE_W'(1);
    assign dim_h_m1 = dim_h - SIZE_W'(1);

    // Integer position saturates at the last column / row
    assign ix    = gx_reg[POS_W-1:FRAC_W];
    assign iy    = gy_reg[POS_W-1:FRAC_W];
    assign sat_x = (ix >= IPOS_W'(dim_w_m1));
    assign sat_y = (iy >= IPOS_W'(dim_h_m1));

    // Weights sum to exactly 2^32
    assign nfx  = ONE_Q - {1'b0, fx_reg};
    assign nfy  = ONE_Q - {1'b0, fy_reg};
    assign wp00 = (2*FRAC_W+2)'(nfx) * (2*FRAC_W+2)'(nfy);
    assign wp10 = (2*FRAC_W+2)'(fx_reg) * (2*FRAC_W+2)'(nfy);
    assign wp01 = (2*FRAC_W+2)'(nfx) * (2*FRAC_W+2)'(fy_reg);
    assign wp11 = (2*FRAC_W+2)'(fx_reg) * (2*FRAC_W+2)'(fy_reg);

    // Missing right / bottom neighbor reads the base pixel again
    assign row_base = (2*SIZE_W)'(yi_reg) * (2*SIZE_W)'(dim_w);
    assign a00 = row_base[STORE_AW-1:0] + STORE_AW'(xi_reg);
    assign a10 = right_reg ? a00 + STORE_AW'(1) : a00;
    assign a01 = down_reg ? a00 + STORE_AW'(dim_w) : a00;
    assign a11 = (right_reg && down_reg) ? a00 + STORE_AW'(dim_w) + STORE_AW'(1) : a00;

    assign rd_en   = (state_reg == S_READ);
    assign rd_addr = addr_reg[rd_cnt_reg];
    assign wsel    = weight_reg[acc_sel_reg];

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            prod[c] = (ACC_W + 1)'(rd_data_reg[c*CHAN_W +: CHAN_W]) * (ACC_W + 1)'(wsel);
            out_pack[c*CHAN_W +: CHAN_W] = acc_reg[c][ACC_W-1 -: CHAN_W];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (item_take && cmd == CMD_SAMPLE)
                    state_next = S_LOC;
            S_LOC:
                state_next = S_WGT;
            S_WGT:
                state_next = S_READ;
            S_READ:
                if (rd_cnt_reg == 2'd3)
                    state_next = S_ACC;
            S_ACC:
                state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            src_width_reg  <= SIZE_W'(1);
            src_height_reg <= SIZE_W'(1);
            x_step_reg     <= '0;
            y_step_reg     <= '0;
            rd_cnt_reg     <= '0;
            acc_en_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_en_reg <= rd_en;

            if (state_reg == S_WGT)
                rd_cnt_reg <= '0;
            else if (rd_en)
                rd_cnt_reg <= rd_cnt_reg + 2'd1;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SIZE_W-1:0];
                    CFG_X_STEP:     x_step_reg     <= cfg_data[STEP_W-1:0];
                    CFG_Y_STEP:     y_step_reg     <= cfg_data[STEP_W-1:0];
                    default:        ;
                endcase
            end

            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            gx_reg <= POS_W'(dest_x) * POS_W'(x_step_reg);
            gy_reg <= POS_W'(dest_y) * POS_W'(y_step_reg);
        end

        if (state_reg == S_LOC)
        begin
            xi_reg    <= sat_x ? dim_w_m1 : ix[SIZE_W-1:0];
            yi_reg    <= sat_y ? dim_h_m1 : iy[SIZE_W-1:0];
            fx_reg    <= sat_x ? '0 : gx_reg[FRAC_W-1:0];
            fy_reg    <= sat_y ? '0 : gy_reg[FRAC_W-1:0];
            right_reg <= !sat_x;
            down_reg  <= !sat_y;
        end

        if (state_reg == S_WGT)
        begin
            weight_reg[0] <= wp00[WGT_W-1:0];
            weight_reg[1] <= wp10[WGT_W-1:0];
            weight_reg[2] <= wp01[WGT_W-1:0];
            weight_reg[3] <= wp11[WGT_W-1:0];
            addr_reg[0]   <= a00;
            addr_reg[1]   <= a10;
            addr_reg[2]   <= a01;
            addr_reg[3]   <= a11;
            for (int c = 0; c < NUM_CHAN; c++)
                acc_reg[c] <= '0;
        end
        else if (acc_en_reg)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
                acc_reg[c] <= acc_reg[c] + prod[c][ACC_W-1:0];
        end

        if (rd_en)
            acc_sel_reg <= rd_cnt_reg;

        if (state_reg == S_OUT && out_free)
            out_rgba_reg <= out_pack;
    end

    // Single-port pixel store: writes only while idle, reads only in S_READ
    always_ff @(posedge clk)
    begin
        if (item_take && cmd == CMD_WRITE)
            store_mem[pixel_index] <= pixel_rgba;
        else if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

endmodule

FILE: dv/tb_bilinear_rgba_resampler_unit.sv
`timescale 1ns / 100ps

module tb_bilinear_rgba_resampler_unit;
    import brr_pkg::*;

    localparam int unsigned CLK_HALF     = 6;
    // Drain time, chosen longer than a sample holds the item side.
    localparam int unsigned DRAIN_CYCLES = 16;
    // Directed beats plus roughly 600 random ones.
    localparam int unsigned ITEM_TARGET  = 620;
    localparam int unsigned LIMIT_NS     = 10_000_000;
    localparam int unsigned MAX_PRINTS   = 40;
    localparam int unsigned STORE_DEPTH  = 1 << STORE_AW;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;

    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic                cmd          = 1'b0;
    logic [STORE_AW-1:0] pixel_index  = '0;
    logic [PIX_W-1:0]    pixel_rgba   = '0;
    logic [DEST_W-1:0]   dest_x       = '0;
    logic [DEST_W-1:0]   dest_y       = '0;

    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [PIX_W-1:0]    out_rgba;

    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [CFG_AW-1:0]   cfg_index    = '0;
    logic [31:0]         cfg_data     = '0;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the pixel store and the size/step registers,
    // computes the blended pixel for every accepted sample beat and
    // holds those pixels in order until the result side delivers them.
    // ------------------------------------------------------------------
    class blend_scoreboard;
        bit [PIX_W-1:0]  pix_store [int unsigned];  // an entry exists once written
        bit [SIZE_W-1:0] width_reg;
        bit [SIZE_W-1:0] height_reg;
        bit [STEP_W-1:0] x_step_reg;
        bit [STEP_W-1:0] y_step_reg;
        bit [PIX_W-1:0]  expected_rgba [$];
        int unsigned     errors;

        function new();
            width_reg  = SIZE_W'(1);
            height_reg = SIZE_W'(1);
            x_step_reg = '0;
            y_step_reg = '0;
            errors     = 0;
        endfunction

        static function int unsigned clamp_size(bit [SIZE_W-1:0] raw, int unsigned top);
            if (raw == 0)
                return 1;
            if (32'(raw) > top)
                return top;
            return 32'(raw);
        endfunction

        function void note_config(cfg_idx_t idx, bit [31:0] data);
            case (idx)
                CFG_SRC_WIDTH:  width_reg  = data[SIZE_W-1:0];
                CFG_SRC_HEIGHT: height_reg = data[SIZE_W-1:0];
                CFG_X_STEP:     x_step_reg = data[STEP_W-1:0];
                CFG_Y_STEP:     y_step_reg = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // dest * step in Q20.16; integer part saturates at the last column/row
        static function void locate(bit [DEST_W-1:0] dest, bit [STEP_W-1:0] step,
                                    int unsigned limit, output int unsigned ipos,
                                    output int unsigned frac);
            bit [POS_W-1:0] prod;
            prod = POS_W'(dest) * POS_W'(step);
            if (32'(prod[POS_W-1:FRAC_W]) >= limit - 1)
            begin
                ipos = limit - 1;
                frac = 0;
            end
            else
            begin
                ipos = 32'(prod[POS_W-1:FRAC_W]);
                frac = 32'(prod[FRAC_W-1:0]);
            end
        endfunction

        // Store addresses of base, right, below and diagonal neighbor.
        // A neighbor off the image falls back to the base pixel.
        function void neighbors(bit [DEST_W-1:0] dx, bit [DEST_W-1:0] dy,
                                output int unsigned addr [4],
                                output int unsigned fx, output int unsigned fy);
            int unsigned w;
            int unsigned h;
            int unsigned xi;
            int unsigned yi;
            bit          right_ok;
            bit          below_ok;
            w = clamp_size(width_reg, MAX_WIDTH_DEF);
            h = clamp_size(height_reg, MAX_HEIGHT_DEF);
            locate(dx, x_step_reg, w, xi, fx);
            locate(dy, y_step_reg, h, yi, fy);
            right_ok = (xi + 1 < w);
            below_ok = (yi + 1 < h);
            addr[0] = (yi * w + xi) % STORE_DEPTH;
            addr[1] = right_ok ? (yi * w + xi + 1) % STORE_DEPTH : addr[0];
            addr[2] = below_ok ? ((yi + 1) * w + xi) % STORE_DEPTH : addr[0];
            addr[3] = (right_ok && below_ok) ? ((yi + 1) * w + xi + 1) % STORE_DEPTH
                                             : addr[0];
        endfunction

        function bit [PIX_W-1:0] blend(bit [DEST_W-1:0] dx, bit [DEST_W-1:0] dy);
            int unsigned     addr [4];
            int unsigned     fx;
            int unsigned     fy;
            bit [PIX_W-1:0]  px [4];
            longint unsigned wgt [4];
            longint unsigned fxl;
            longint unsigned fyl;
            longint unsigned acc;
            longint unsigned chan;
            bit [PIX_W-1:0]  rgba;
            int              c;
            int              k;
            neighbors(dx, dy, addr, fx, fy);
            for (k = 0; k < 4; k++)
                px[k] = pix_store.exists(addr[k]) ? pix_store[addr[k]] : '0;
            fxl    = 64'(fx);
            fyl    = 64'(fy);
            // weights are 17-bit fractions; the four products add up to 2^32
            wgt[0] = (64'd65536 - fxl) * (64'd65536 - fyl);
            wgt[1] = fxl * (64'd65536 - fyl);
            wgt[2] = (64'd65536 - fxl) * fyl;
            wgt[3] = fxl * fyl;
            rgba   = '0;
            for (c = 0; c < NUM_CHAN; c++)
            begin
                acc = 0;
                for (k = 0; k < 4; k++)
                    acc += wgt[k] * 64'(px[k][c*CHAN_W +: CHAN_W]);
                chan = acc >> 32;
                if (chan > 255)
                    chan = 255;
                rgba[c*CHAN_W +: CHAN_W] = chan[CHAN_W-1:0];
            end
            return rgba;
        endfunction

        function void note_item(cmd_t kind, bit [STORE_AW-1:0] idx, bit [PIX_W-1:0] rgba,
                                bit [DEST_W-1:0] dx, bit [DEST_W-1:0] dy);
            if (kind == CMD_WRITE)
                pix_store[idx] = rgba;
            else
                expected_rgba.push_back(blend(dx, dy));
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task check_rgba(logic [PIX_W-1:0] got);
            bit [PIX_W-1:0] want;
            if (expected_rgba.size() == 0)
            begin
                report($sformatf("result beat %08h with no sample pending", got));
                return;
            end
            want = expected_rgba.pop_front();
            if (got !== want)
                report($sformatf("out_rgba got %08h want %08h", got, want));
        endtask

        function int unsigned pending();
            return expected_rgba.size();
        endfunction
    endclass

    blend_scoreboard sb;
    int unsigned     items_sent;
    bit              no_idle;    // set for phases that run back-to-back beats

    bilinear_rgba_resampler_unit #(
        .MAX_WIDTH  (MAX_WIDTH_DEF),
        .MAX_HEIGHT (MAX_HEIGHT_DEF)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .pixel_index  (pixel_index),
        .pixel_rgba   (pixel_rgba),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_rgba     (out_rgba),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin : clock_gen
        forever #(CLK_HALF) clk = ~clk;
    end

    // Overall limit, far above the slowest legal run.
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("tb_bilinear_rgba_resampler_unit: done, errors");
        $finish;
    end

    // Result-side back-pressure: runs of free flow, sparse random stalls,
    // and now and then a long hold.
    initial
    begin : stall_gen
        int unsigned run_len;
        int unsigned mode;
        forever
        begin
            run_len = $urandom_range(1, 40);
            mode    = $urandom_range(0, 9);
            repeat (run_len)
            begin
                @(posedge clk);
                if (mode < 4)
                    result_stall <= 1'b0;
                else if (mode < 9)
                    result_stall <= ($urandom_range(0, 3) == 0);
                else
                    result_stall <= 1'b1;
            end
        end
    end

    // Result monitor. Values read right after the edge are the ones the
    // DUT saw at that edge, since every TB drive is nonblocking.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_rgba(out_rgba);
    end

    // Mostly short gaps, a few long ones, none in back-to-back phases.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a rising edge; returns after the accept, once item_stall is low.
    // item_valid stays high on return so the next beat can follow at once.
    task automatic send_item(cmd_t kind, bit [STORE_AW-1:0] idx, bit [PIX_W-1:0] rgba,
                             bit [DEST_W-1:0] dx, bit [DEST_W-1:0] dy);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        cmd         <= kind;
        pixel_index <= idx;
        pixel_rgba  <= rgba;
        dest_x      <= dx;
        dest_y      <= dy;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(kind, idx, rgba, dx, dy);
        items_sent++;
    endtask

    // Unused dest fields carry noise on writes.
    task automatic write_pixel(bit [STORE_AW-1:0] idx, bit [PIX_W-1:0] rgba);
        send_item(CMD_WRITE, idx, rgba, DEST_W'($urandom), DEST_W'($urandom));
    endtask

    // Any neighbor that was never written gets a random pixel first, so the
    // DUT never reads an undefined store entry. Unused write fields carry noise.
    task automatic sample_at(bit [DEST_W-1:0] dx, bit [DEST_W-1:0] dy);
        int unsigned addr [4];
        int unsigned fx;
        int unsigned fy;
        int          k;
        sb.neighbors(dx, dy, addr, fx, fy);
        for (k = 0; k < 4; k++)
        begin
            if (!sb.pix_store.exists(addr[k]))
                write_pixel(STORE_AW'(addr[k]), $urandom);
        end
        send_item(CMD_SAMPLE, STORE_AW'($urandom), $urandom, dx, dy);
    endtask

    // Drop item_valid, wait for every pending result, then let the DUT
    // finish anything still in flight (trailing writes give no result).
    task automatic settle();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cfg_valid is held across the four beats and dropped after the last.
    task automatic set_reg(cfg_idx_t idx, bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_config(idx, data);
    endtask

    task automatic configure(bit [31:0] w_data, bit [31:0] h_data,
                             bit [31:0] x_data, bit [31:0] y_data);
        settle();
        set_reg(CFG_SRC_WIDTH,  w_data);
        set_reg(CFG_SRC_HEIGHT, h_data);
        set_reg(CFG_X_STEP,     x_data);
        set_reg(CFG_Y_STEP,     y_data);
        cfg_valid <= 1'b0;
    endtask

    // Mostly the driver formula floor(((src-1)<<16)/dst), for up- and
    // down-scaling; otherwise zero, all ones, or any 24-bit value.
    function automatic bit [STEP_W-1:0] pick_step(int unsigned src, output int unsigned dst);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            dst = $urandom_range(1, 2 * src + 8);
        else
            dst = $urandom_range(1, 1 << DEST_W);
        if (r == 7)
            return '0;
        if (r == 8)
            return '1;
        if (r == 9)
            return STEP_W'($urandom);
        return STEP_W'(((src - 1) << FRAC_W) / dst);
    endfunction

    // Upper register bits are don't-care; sometimes fill them with noise.
    function automatic bit [31:0] size_word(int unsigned raw);
        bit [31:0] noise;
        noise = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
        return {noise[31:SIZE_W], raw[SIZE_W-1:0]};
    endfunction

    // One random phase: new geometry and steps, an optional row-major fill,
    // then a mix of samples (mostly inside the destination frame), samples
    // anywhere in the 12-bit range and stray writes.
    task automatic run_phase();
        int unsigned     w_raw;
        int unsigned     h_raw;
        int unsigned     w;
        int unsigned     h;
        int unsigned     dst_w;
        int unsigned     dst_h;
        int unsigned     n_items;
        int unsigned     r;
        int unsigned     i;
        bit [STEP_W-1:0] xs;
        bit [STEP_W-1:0] ys;
        bit [31:0]       noise;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            w_raw = $urandom_range(1, 12);
            h_raw = $urandom_range(1, 12);
        end
        else if (r < 8)
        begin
            w_raw = $urandom_range(1, MAX_WIDTH_DEF);
            h_raw = $urandom_range(1, MAX_HEIGHT_DEF);
        end
        else
        begin
            // includes 0 and values past the maximum, both clamped
            w_raw = $urandom_range(0, SIZE_MAX);
            h_raw = $urandom_range(0, SIZE_MAX);
        end
        w  = blend_scoreboard::clamp_size(SIZE_W'(w_raw), MAX_WIDTH_DEF);
        h  = blend_scoreboard::clamp_size(SIZE_W'(h_raw), MAX_HEIGHT_DEF);
        xs = pick_step(w, dst_w);
        ys = pick_step(h, dst_h);
        noise = $urandom;
        configure(size_word(w_raw), size_word(h_raw),
                  {noise[31:24], xs}, {noise[23:16], ys});
        no_idle = ($urandom_range(0, 3) == 0);
        if (w * h <= 256 && $urandom_range(0, 1) == 1)
        begin
            for (i = 0; i < w * h; i++)
                write_pixel(STORE_AW'(i), $urandom);
        end
        n_items = $urandom_range(40, 100);
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                sample_at(DEST_W'($urandom_range(0, dst_w - 1)),
                          DEST_W'($urandom_range(0, dst_h - 1)));
            else if (r < 85)
                sample_at(DEST_W'($urandom), DEST_W'($urandom));
            else if (r < 93)
                write_pixel(STORE_AW'($urandom), $urandom);
            else
                write_pixel(STORE_AW'($urandom_range(0, w * h - 1)), $urandom);
        end
    endtask

    initial
    begin : stimulus
        sb         = new();
        items_sent = 0;
        no_idle    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: 1x1 image, zero steps, so every dest maps to pixel 0.
        write_pixel(16'h0000, 32'hFFFF_FFFF);
        sample_at('0, '0);
        sample_at('1, '1);
        write_pixel(16'hFFFF, 32'h0000_0000);    // top of the store
        write_pixel(16'h0000, 32'h8040_2010);
        sample_at('1, '0);

        // 2x2 image, half-pixel steps: exact midpoint blend, edge fallback,
        // and a far dest that saturates on both axes.
        configure(32'd2, 32'd2, 32'h0000_8000, 32'h0000_8000);
        write_pixel(16'd0, 32'hFFFF_FFFF);
        write_pixel(16'd1, 32'h0000_0000);
        write_pixel(16'd2, 32'h00FF_00FF);
        write_pixel(16'd3, 32'hFF00_FF00);
        sample_at(12'd0, 12'd0);
        sample_at(12'd1, 12'd1);
        sample_at(12'd1, 12'd0);
        sample_at(12'd0, 12'd1);
        sample_at('1, '1);

        // Width 0 (taken as 1), height 511 (taken as max), max x step with
        // junk above bit 23, y step of one LSB giving a tiny fraction.
        configure(32'hFFFF_FE00, 32'h0000_01FF, 32'hFFFF_FFFF, 32'h0000_0001);
        sample_at('1, '1);
        sample_at('1, 12'd0);

        // Largest image: full-step position lands on the last pixel of the store.
        configure(32'd256, 32'd256, 32'h00FF_FFFF, 32'h00FF_0000);
        sample_at(12'd1, 12'd1);
        sample_at(12'd0, 12'd0);

        while (items_sent < ITEM_TARGET)
            run_phase();

        settle();
        if (sb.errors == 0)
            $display("tb_bilinear_rgba_resampler_unit: done, clean");
        else
            $display("tb_bilinear_rgba_resampler_unit: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/brr_pkg.sv
src/bilinear_rgba_resampler_unit.sv
dv/tb_bilinear_rgba_resampler_unit.sv
